>>> sv/ntg_pkg.sv
// shared types, constants and helper functions of the note tone generator
package ntg_pkg;

  localparam int SINE_TABLE_BITS = 10;
  localparam int FRAME_BITS      = 24;
  localparam int PHASE_BITS      = 32;

  localparam int SR_W       = 18;
  localparam int SINE_W     = 15;
  localparam int QUARTER    = 1 << (SINE_TABLE_BITS - 2);
  localparam int ZIDX_W     = SINE_TABLE_BITS - 1;
  localparam int DIV_NUM_W  = 48;
  localparam int DIV_CNT_W  = 6;
  localparam logic [SR_W-1:0] SR_RESET = SR_W'(44100);

  // polynomial coefficients for the quarter-wave sine, Q30
  localparam longint unsigned PC1 = 64'd1686629713;
  localparam longint unsigned PC3 = 64'd693598668;
  localparam longint unsigned PC5 = 64'd85569306;
  localparam longint unsigned PC7 = 64'd5026997;
  localparam longint unsigned PC9 = 64'd172272;

  // datapath operations
  localparam logic [4:0] OP_NONE      = 5'd0;
  localparam logic [4:0] OP_LATCH     = 5'd1;
  localparam logic [4:0] OP_HZ        = 5'd2;
  localparam logic [4:0] OP_DIV_TONE  = 5'd3;
  localparam logic [4:0] OP_TONE_SET  = 5'd4;
  localparam logic [4:0] OP_DIV_WOB   = 5'd5;
  localparam logic [4:0] OP_WOB_SET   = 5'd6;
  localparam logic [4:0] OP_SIN0      = 5'd7;
  localparam logic [4:0] OP_SIN1      = 5'd8;
  localparam logic [4:0] OP_SIN2      = 5'd9;
  localparam logic [4:0] OP_SIN3      = 5'd10;
  localparam logic [4:0] OP_FAC       = 5'd11;
  localparam logic [4:0] OP_ENV_START = 5'd12;
  localparam logic [4:0] OP_ENV_SET   = 5'd13;
  localparam logic [4:0] OP_MUL1      = 5'd14;
  localparam logic [4:0] OP_MUL2      = 5'd15;
  localparam logic [4:0] OP_MUL3      = 5'd16;
  localparam logic [4:0] OP_RECIP     = 5'd17;
  localparam logic [4:0] OP_QEST      = 5'd18;
  localparam logic [4:0] OP_CORR      = 5'd19;
  localparam logic [4:0] OP_EMIT      = 5'd20;

  typedef struct packed {
    logic        start_req;
    logic [6:0]  midi_note;
    logic [6:0]  velocity;
    logic [23:0] frame_count;
    logic [15:0] vibrato_depth;
    logic [15:0] vibrato_rate;
  } in_item_t;

  typedef struct packed {
    logic signed [15:0] sample;
    logic               active;
    logic               last;
  } out_item_t;

  typedef struct packed {
    logic [4:0] op;
  } ntg_cmd_t;

  typedef struct packed {
    logic start;
    logic act;
    logic div_busy;
    logic out_free;
  } ntg_status_t;

  typedef struct packed {
    logic                  start;
    logic [FRAME_BITS-1:0] rem;
    logic [DIV_NUM_W-1:0]  num;
    logic [FRAME_BITS-1:0] divisor;
    logic [DIV_CNT_W-1:0]  steps;
  } ntg_div_req_t;

  function automatic logic [16:0] semitone_q16(input logic [3:0] r);
    case (r)
      4'd0:    return 17'd65536;
      4'd1:    return 17'd69433;
      4'd2:    return 17'd73562;
      4'd3:    return 17'd77936;
      4'd4:    return 17'd82570;
      4'd5:    return 17'd87480;
      4'd6:    return 17'd92682;
      4'd7:    return 17'd98193;
      4'd8:    return 17'd104032;
      4'd9:    return 17'd110218;
      4'd10:   return 17'd116772;
      4'd11:   return 17'd123715;
      default: return 17'd65536;
    endcase
  endfunction

  // quarter-wave sine point k in Q14, evaluated at elaboration
  function automatic logic [SINE_W-1:0] sine_poly(input int unsigned k);
    longint unsigned z, z2, s, y;
    z  = longint'(k) << (17 - SINE_TABLE_BITS);
    z2 = z * z;
    s  = PC9;
    s  = PC7 - ((z2 * s) >> 30);
    s  = PC5 - ((z2 * s) >> 30);
    s  = PC3 - ((z2 * s) >> 30);
    s  = PC1 - ((z2 * s) >> 30);
    y  = (z * s + (64'd1 << 30)) >> 31;
    return SINE_W'(y);
  endfunction

endpackage

>>> sv/ntg_div.sv
// bit-serial restoring divider shared by pitch, vibrato and envelope
module ntg_div (
  input  logic                          clk,
  input  logic                          rst,
  input  ntg_pkg::ntg_div_req_t         req,
  output logic                          busy,
  output logic [ntg_pkg::DIV_NUM_W-1:0] quot
);
  import ntg_pkg::*;

  logic [FRAME_BITS-1:0] rem;
  logic [FRAME_BITS-1:0] divisor;
  logic [DIV_NUM_W-1:0]  num;
  logic [DIV_CNT_W-1:0]  cnt;
  logic [FRAME_BITS:0]   rem_sh;
  logic                  ge;
  logic [FRAME_BITS:0]   rem_sub;

  assign rem_sh  = {rem, num[DIV_NUM_W-1]};
  assign ge      = rem_sh >= {1'b0, divisor};
  assign rem_sub = rem_sh - {1'b0, divisor};
  assign quot    = num;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      cnt  <= '0;
    end else if (req.start) begin
      busy <= 1'b1;
      cnt  <= req.steps;
    end else if (busy) begin
      cnt <= cnt - 1'b1;
      if (cnt == DIV_CNT_W'(1)) begin
        busy <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      rem     <= req.rem;
      num     <= req.num;
      divisor <= req.divisor;
    end else if (busy) begin
      rem <= ge ? rem_sub[FRAME_BITS-1:0] : rem_sh[FRAME_BITS-1:0];
      num <= {num[DIV_NUM_W-2:0], ge};
    end
  end

endmodule

>>> sv/ntg_datapath.sv
// note state, sine lookup, envelope, multiplies and output register
module ntg_datapath (
  input  logic                         clk,
  input  logic                         rst,
  input  ntg_pkg::ntg_cmd_t            cmd,
  output ntg_pkg::ntg_status_t         status,
  input  ntg_pkg::in_item_t            in_data,
  input  logic                         cfg_we,
  input  logic [ntg_pkg::SR_W-1:0]     cfg_data,
  output logic                         out_valid,
  input  logic                         out_stall,
  output ntg_pkg::out_item_t           out_data
);
  import ntg_pkg::*;

  localparam logic [22:0] SAT_LIM   = 23'd4161663;  // 127 * 32769
  localparam logic [15:0] RECIP_K   = 16'd33027;
  localparam logic [58:0] ROUND_HLF = 59'd127 << 35;

  // note state
  logic [SR_W-1:0]       sample_rate;
  logic [PHASE_BITS-1:0] tone_phase, tone_step, wobble_phase, wobble_step;
  logic [FRAME_BITS-1:0] frame_index, note_length;
  logic [6:0]            loudness;
  logic [15:0]           wobble_depth;
  logic                  playing;

  // per item working registers
  logic                  start_q;
  logic [6:0]            note_q;
  logic [15:0]           rate_q;
  logic [29:0]           hz;
  logic signed [15:0]    sine_q;
  logic signed [17:0]    wave;
  logic [16:0]           fac;
  logic [16:0]           env;
  logic                  env_div;
  logic [33:0]           env_fac;
  logic [23:0]           wl;
  logic [57:0]           mag;
  logic [21:0]           xc;
  logic [15:0]           q0, q;

  logic                  act, fin;
  logic                  div_busy;
  logic [DIV_NUM_W-1:0]  div_quot;
  ntg_div_req_t          div_req;

  // sine table
  logic [SINE_W-1:0] sine_rom [0:QUARTER];
  for (genvar k = 0; k <= QUARTER; k++) begin : g_rom
    assign sine_rom[k] = sine_poly(k);
  end

  logic [PHASE_BITS-1:0]      ph2, ph3, ph_sel;
  logic [SINE_TABLE_BITS-1:0] sidx;
  logic [ZIDX_W-1:0]          zk;
  logic [SINE_W-1:0]          sy;
  logic signed [15:0]         sine_val;

  assign ph2 = {tone_phase[PHASE_BITS-2:0], 1'b0};
  assign ph3 = tone_phase + ph2;

  always_comb begin
    case (cmd.op)
      OP_SIN1: ph_sel = ph2;
      OP_SIN2: ph_sel = ph3;
      OP_SIN3: ph_sel = wobble_phase;
      default: ph_sel = tone_phase;
    endcase
    sidx = ph_sel[PHASE_BITS-1 -: SINE_TABLE_BITS];
    if (sidx[SINE_TABLE_BITS-2]) begin
      zk = ZIDX_W'(QUARTER) - {1'b0, sidx[SINE_TABLE_BITS-3:0]};
    end else begin
      zk = {1'b0, sidx[SINE_TABLE_BITS-3:0]};
    end
    sy = sine_rom[zk];
    sine_val = sidx[SINE_TABLE_BITS-1] ? -$signed({1'b0, sy}) : $signed({1'b0, sy});
  end

  // pitch: octave and semitone of note + 3
  logic [7:0]  u;
  logic [3:0]  oct;
  logic [3:0]  semi;
  logic [26:0] hz0;
  logic [2:0]  rsh;
  logic [29:0] hz_calc;

  always_comb begin
    u    = {1'b0, note_q} + 8'd3;
    oct  = 4'((16'(u) * 16'd171) >> 11);
    semi = 4'(u - 8'(oct) * 8'd12);
    hz0  = 27'(semitone_q16(semi)) * 27'd440;
    rsh  = 3'(4'd6 - oct);
    if (oct >= 4'd6) begin
      hz_calc = 30'(hz0) << (oct - 4'd6);
    end else begin
      hz_calc = 30'((hz0 + (27'd1 << (rsh - 3'd1))) >> rsh);
    end
  end

  // envelope region
  logic [SR_W-1:0] sr_eff;
  logic [28:0]     i20, n19, ni20;
  assign sr_eff = (sample_rate == '0) ? SR_W'(1) : sample_rate;
  assign i20    = 29'(frame_index) * 29'd20;
  assign n19    = 29'(note_length) * 29'd19;
  assign ni20   = 29'(note_length - frame_index) * 29'd20;

  always_comb begin
    div_req         = '0;
    div_req.divisor = FRAME_BITS'({sr_eff, 1'b0});
    div_req.steps   = DIV_CNT_W'(DIV_NUM_W);
    case (cmd.op)
      OP_DIV_TONE: begin
        div_req.start = 1'b1;
        div_req.num   = {1'b0, hz, 17'b0} + DIV_NUM_W'(sr_eff);
      end
      OP_DIV_WOB: begin
        div_req.start = 1'b1;
        div_req.num   = DIV_NUM_W'({rate_q, 25'b0}) + DIV_NUM_W'(sr_eff);
      end
      OP_ENV_START: begin
        div_req.divisor = note_length;
        div_req.steps   = DIV_CNT_W'(16);
        if (i20 < 29'(note_length)) begin
          div_req.start = 1'b1;
          div_req.rem   = i20[FRAME_BITS-1:0];
        end else if (i20 > n19) begin
          div_req.start = 1'b1;
          div_req.rem   = ni20[FRAME_BITS-1:0];
        end
      end
      default: ;
    endcase
  end

  ntg_div u_div (
    .clk  (clk),
    .rst  (rst),
    .req  (div_req),
    .busy (div_busy),
    .quot (div_quot)
  );

  assign act = playing && (frame_index < note_length);
  assign fin = act && (frame_index == note_length - 1'b1);

  assign status.start    = start_q;
  assign status.act      = act;
  assign status.div_busy = div_busy;
  assign status.out_free = !out_valid || !out_stall;

  // vibrato factor and product helpers
  logic signed [32:0] dprod;
  logic [32:0]        dmag;
  logic [16:0]        dsh;
  logic [16:0]        wave_mag;
  logic [16:0]        ef_part;
  logic [40:0]        pp;
  logic [58:0]        tsum;
  logic [22:0]        xq;
  logic [37:0]        qprod;
  logic [22:0]        q127;
  logic signed [15:0] smp;

  always_comb begin
    dprod    = 33'(signed'({1'b0, wobble_depth})) * 33'(sine_q);
    dmag     = dprod[32] ? 33'(-dprod) : 33'(dprod);
    dsh      = 17'(dmag >> 14);
    wave_mag = wave[17] ? 17'(-wave) : 17'(wave);
    ef_part  = (cmd.op == OP_MUL3) ? env_fac[33:17] : env_fac[16:0];
    pp       = 41'(wl) * 41'(ef_part);
    tsum     = 59'(mag) + ROUND_HLF;
    xq       = tsum[58:36];
    qprod    = 38'(xc) * 38'(RECIP_K);
    q127     = 23'(q0) * 23'd127;
    if (wave[17]) begin
      smp = (q > 16'd32768) ? -16'sd32768 : 16'(-$signed({1'b0, q}));
    end else begin
      smp = (q > 16'd32767) ? 16'sd32767 : $signed(q);
    end
  end

  // note state and configuration
  always_ff @(posedge clk) begin
    if (rst) begin
      sample_rate  <= SR_RESET;
      tone_phase   <= '0;
      tone_step    <= '0;
      wobble_phase <= '0;
      wobble_step  <= '0;
      frame_index  <= '0;
      note_length  <= '0;
      loudness     <= '0;
      wobble_depth <= '0;
      playing      <= 1'b0;
      out_valid    <= 1'b0;
    end else begin
      if (cfg_we) begin
        sample_rate <= cfg_data;
      end
      if (cmd.op == OP_EMIT) begin
        out_valid <= 1'b1;
      end else if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end
      case (cmd.op)
        OP_LATCH: begin
          if (in_data.start_req) begin
            note_length  <= in_data.frame_count;
            loudness     <= in_data.velocity;
            wobble_depth <= in_data.vibrato_depth;
            tone_phase   <= '0;
            wobble_phase <= '0;
            frame_index  <= '0;
            playing      <= in_data.frame_count != '0;
          end
        end
        OP_TONE_SET: tone_step <= div_quot[PHASE_BITS-1:0];
        OP_WOB_SET: begin
          wobble_step <= (wobble_depth < 16'd66) ? '0 : div_quot[PHASE_BITS-1:0];
        end
        OP_EMIT: begin
          if (act) begin
            tone_phase   <= tone_phase + tone_step;
            wobble_phase <= wobble_phase + wobble_step;
            frame_index  <= frame_index + 1'b1;
            if (fin) begin
              playing <= 1'b0;
            end
          end
        end
        default: ;
      endcase
    end
  end

  // working registers
  always_ff @(posedge clk) begin
    case (cmd.op)
      OP_LATCH: begin
        start_q <= in_data.start_req;
        note_q  <= in_data.midi_note;
        rate_q  <= in_data.vibrato_rate;
      end
      OP_HZ:   hz <= hz_calc;
      OP_SIN0: sine_q <= sine_val;
      OP_SIN1: begin
        sine_q <= sine_val;
        wave   <= 18'(sine_q) <<< 2;
      end
      OP_SIN2: begin
        sine_q <= sine_val;
        wave   <= wave + (18'(sine_q) <<< 1);
      end
      OP_SIN3: begin
        sine_q <= sine_val;
        wave   <= wave + 18'(sine_q);
      end
      OP_FAC: begin
        if (wobble_step == '0) begin
          fac <= 17'd65536;
        end else if (dprod[32]) begin
          fac <= 17'd65536 - dsh;
        end else begin
          fac <= 17'd65536 + dsh;
        end
      end
      OP_ENV_START: begin
        env     <= 17'd65536;
        env_div <= div_req.start;
      end
      OP_ENV_SET: begin
        if (env_div) begin
          env <= {1'b0, div_quot[15:0]};
        end
      end
      OP_MUL1: begin
        env_fac <= 34'(env) * 34'(fac);
        wl      <= 24'(wave_mag) * 24'(loudness);
      end
      OP_MUL2: mag <= 58'(pp);
      OP_MUL3: mag <= mag + {pp, 17'b0};
      OP_RECIP: xc <= (xq > SAT_LIM) ? SAT_LIM[21:0] : xq[21:0];
      OP_QEST: q0 <= qprod[37:22];
      OP_CORR: q <= (q127 > 23'(xc)) ? q0 - 1'b1 : q0;
      OP_EMIT: begin
        out_data.sample <= act ? smp : '0;
        out_data.active <= act;
        out_data.last   <= fin;
      end
      default: ;
    endcase
  end

endmodule

>>> sv/ntg_ctrl.sv
// sequencer that steps the datapath through one tick
module ntg_ctrl (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  ntg_pkg::ntg_status_t status,
  output ntg_pkg::ntg_cmd_t    cmd
);
  import ntg_pkg::*;

  localparam logic [4:0] S_IDLE   = 5'd0;
  localparam logic [4:0] S_BRANCH = 5'd1;
  localparam logic [4:0] S_HZ     = 5'd2;
  localparam logic [4:0] S_DTONE  = 5'd3;
  localparam logic [4:0] S_WTONE  = 5'd4;
  localparam logic [4:0] S_DWOB   = 5'd5;
  localparam logic [4:0] S_WWOB   = 5'd6;
  localparam logic [4:0] S_SIN0   = 5'd7;
  localparam logic [4:0] S_SIN1   = 5'd8;
  localparam logic [4:0] S_SIN2   = 5'd9;
  localparam logic [4:0] S_SIN3   = 5'd10;
  localparam logic [4:0] S_FAC    = 5'd11;
  localparam logic [4:0] S_ENV    = 5'd12;
  localparam logic [4:0] S_WENV   = 5'd13;
  localparam logic [4:0] S_MUL1   = 5'd14;
  localparam logic [4:0] S_MUL2   = 5'd15;
  localparam logic [4:0] S_MUL3   = 5'd16;
  localparam logic [4:0] S_RECIP  = 5'd17;
  localparam logic [4:0] S_QEST   = 5'd18;
  localparam logic [4:0] S_CORR   = 5'd19;
  localparam logic [4:0] S_EMIT   = 5'd20;

  logic [4:0] state, state_next;

  assign in_stall = state != S_IDLE;

  always_comb begin
    state_next = state;
    cmd.op     = OP_NONE;
    case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd.op     = OP_LATCH;
          state_next = S_BRANCH;
        end
      end
      S_BRANCH: begin
        if (status.start) begin
          state_next = S_HZ;
        end else begin
          state_next = status.act ? S_SIN0 : S_EMIT;
        end
      end
      S_HZ: begin
        cmd.op     = OP_HZ;
        state_next = S_DTONE;
      end
      S_DTONE: begin
        cmd.op     = OP_DIV_TONE;
        state_next = S_WTONE;
      end
      S_WTONE: begin
        if (!status.div_busy) begin
          cmd.op     = OP_TONE_SET;
          state_next = S_DWOB;
        end
      end
      S_DWOB: begin
        cmd.op     = OP_DIV_WOB;
        state_next = S_WWOB;
      end
      S_WWOB: begin
        if (!status.div_busy) begin
          cmd.op     = OP_WOB_SET;
          state_next = status.act ? S_SIN0 : S_EMIT;
        end
      end
      S_SIN0: begin
        cmd.op     = OP_SIN0;
        state_next = S_SIN1;
      end
      S_SIN1: begin
        cmd.op     = OP_SIN1;
        state_next = S_SIN2;
      end
      S_SIN2: begin
        cmd.op     = OP_SIN2;
        state_next = S_SIN3;
      end
      S_SIN3: begin
        cmd.op     = OP_SIN3;
        state_next = S_FAC;
      end
      S_FAC: begin
        cmd.op     = OP_FAC;
        state_next = S_ENV;
      end
      S_ENV: begin
        cmd.op     = OP_ENV_START;
        state_next = S_WENV;
      end
      S_WENV: begin
        if (!status.div_busy) begin
          cmd.op     = OP_ENV_SET;
          state_next = S_MUL1;
        end
      end
      S_MUL1: begin
        cmd.op     = OP_MUL1;
        state_next = S_MUL2;
      end
      S_MUL2: begin
        cmd.op     = OP_MUL2;
        state_next = S_MUL3;
      end
      S_MUL3: begin
        cmd.op     = OP_MUL3;
        state_next = S_RECIP;
      end
      S_RECIP: begin
        cmd.op     = OP_RECIP;
        state_next = S_QEST;
      end
      S_QEST: begin
        cmd.op     = OP_QEST;
        state_next = S_CORR;
      end
      S_CORR: begin
        cmd.op     = OP_CORR;
        state_next = S_EMIT;
      end
      S_EMIT: begin
        // hold until the output register can take the result
        if (status.out_free) begin
          cmd.op     = OP_EMIT;
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

endmodule

>>> sv/note_tone_generator_unit.sv
// top level of the note tone generator: sequencer, datapath and checks
//
// channel   direction  handshake             payload
// in        input      in_valid / in_stall   in_data    (ntg_pkg::in_item_t)
// out       output     out_valid / out_stall out_data   (ntg_pkg::out_item_t)
// cfg       input      cfg_valid / cfg_ready cfg_data   (sample_rate, 18 bits)
//
// a tick with no note playing goes from the latch straight to the emit step; inside
// the note it also runs the sine, vibrato, envelope and multiply steps, and on the
// attack and release edges the serial divider also works out the envelope ratio
// a start request adds two 48-step divisions for the phase steps
// one item is in flight at a time; a stalled output holds the item at its last step
// rst is synchronous; sample_rate comes back at 44100 and the note state clears
module note_tone_generator_unit (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       in_valid,
  output logic                       in_stall,
  input  ntg_pkg::in_item_t          in_data,
  output logic                       out_valid,
  input  logic                       out_stall,
  output ntg_pkg::out_item_t         out_data,
  input  logic                       cfg_valid,
  output logic                       cfg_ready,
  input  logic [ntg_pkg::SR_W-1:0]   cfg_data
);
  import ntg_pkg::*;

  ntg_cmd_t    cmd;
  ntg_status_t status;

  assign cfg_ready = 1'b1;

  ntg_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .status   (status),
    .cmd      (cmd)
  );

  ntg_datapath u_dp (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .status    (status),
    .in_data   (in_data),
    .cfg_we    (cfg_valid && cfg_ready),
    .cfg_data  (cfg_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

  // one item at a time: after a transfer in, the input stalls
  a_one_item: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall |=> in_stall)
    else $error("second item taken while one is in flight");

  // the final sample belongs to the note
  a_last_active: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_data.last |-> out_data.active)
    else $error("last flagged outside a note");

  // outside a note the sample is silent
  a_idle_silent: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_data.active |-> out_data.sample == 16'sd0)
    else $error("nonzero sample outside a note");

  // a new result only appears once an item was taken
  a_result_cause: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(in_stall))
    else $error("result without an item in flight");

endmodule

>>> dv/note_tone_generator_unit_tb.sv
// self-checking testbench of the note tone generator: directed notes, random note runs and a sample rate sweep
module note_tone_generator_unit_tb;
  import ntg_pkg::*;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_stall;
  in_item_t in_data = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  out_item_t out_data;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [SR_W-1:0] cfg_data = '0;

  note_tone_generator_unit dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data)
  );

  always #1 clk = ~clk;

  localparam longint unsigned PMASK = 64'hFFFF_FFFF;
  localparam int WATCHDOG_LIMIT = 20000;

  // own copy of the synthesizer state
  longint unsigned rate_hz = 44100;
  longint unsigned tone_ph, tone_inc, wob_ph, wob_inc, frame_at, frame_len;
  int unsigned loud, wob_depth;
  bit sounding;

  out_item_t tick_results_q[$];
  int unsigned fail_count = 0;
  int unsigned notes_started = 0;
  int unsigned notes_ended = 0;
  int unsigned samples_checked = 0;
  int unsigned quiet_cycles = 0;
  bit steady = 1'b0;

  function automatic int sine_q14(longint unsigned ph);
    longint unsigned idx, quad, z, z2, s, y;
    idx = (ph & PMASK) >> (PHASE_BITS - SINE_TABLE_BITS);
    quad = (idx >> (SINE_TABLE_BITS - 2)) & 3;
    z = (idx & ((64'd1 << (SINE_TABLE_BITS - 2)) - 1)) << (17 - SINE_TABLE_BITS);
    if (quad[0]) z = 64'd32768 - z;
    z2 = z * z;
    s = 64'd172272;
    s = 64'd5026997 - ((z2 * s) >> 30);
    s = 64'd85569306 - ((z2 * s) >> 30);
    s = 64'd693598668 - ((z2 * s) >> 30);
    s = 64'd1686629713 - ((z2 * s) >> 30);
    y = (z * s + (64'd1 << 30)) >> 31;
    return quad[1] ? -int'(y) : int'(y);
  endfunction

  function automatic longint unsigned rate_div();
    return (rate_hz == 0) ? 64'd1 : rate_hz;
  endfunction

  function automatic longint unsigned tone_increment(logic [6:0] note);
    longint unsigned ratio[12] = '{65536, 69433, 73562, 77936, 82570, 87480,
                                   92682, 98193, 104032, 110218, 116772, 123715};
    int unsigned u;
    int oct;
    longint unsigned hz, den;
    u = note + 3;
    oct = int'(u / 12) - 6;
    hz = 64'd440 * ratio[u % 12];
    den = rate_div() << 16;
    if (oct >= 0) hz = hz << oct;
    else hz = (hz + (64'd1 << (-oct - 1))) >> (-oct);
    return (((hz << PHASE_BITS) + (den >> 1)) / den) & PMASK;
  endfunction

  function automatic longint unsigned wobble_increment(logic [15:0] r);
    longint unsigned den;
    den = rate_div() << 8;
    return ((longint'(r) << PHASE_BITS) + (den >> 1)) / den & PMASK;
  endfunction

  function automatic out_item_t synth_tick(in_item_t it);
    out_item_t res;
    bit act, fin;
    longint wave, env, fac, prod;
    longint unsigned mag, den, q, i, n;
    res = '0;
    if (it.start_req) begin
      frame_len = it.frame_count;
      loud = it.velocity;
      wob_depth = it.vibrato_depth;
      tone_inc = tone_increment(it.midi_note);
      wob_inc = (wob_depth < 66) ? 0 : wobble_increment(it.vibrato_rate);
      tone_ph = 0;
      wob_ph = 0;
      frame_at = 0;
      sounding = frame_len != 0;
    end
    act = sounding && frame_at < frame_len;
    fin = act && frame_at == frame_len - 1;
    if (act) begin
      i = frame_at;
      n = frame_len;
      wave = 4 * longint'(sine_q14(tone_ph)) + 2 * longint'(sine_q14(tone_ph * 2))
           + longint'(sine_q14(tone_ph * 3));
      if (20 * i < n) env = longint'(((20 * i) << 16) / n);
      else if (20 * i > 19 * n) env = longint'(((20 * (n - i)) << 16) / n);
      else env = 65536;
      if (wob_inc == 0) fac = 65536;
      else fac = 65536 + (longint'(wob_depth) * longint'(sine_q14(wob_ph))) / 16384;
      prod = wave * env * longint'(loud) * fac;
      mag = (prod < 0) ? longint'(-prod) : prod;
      den = 64'd127 << 36;
      q = (mag + (den >> 1)) / den;
      if (prod < 0) res.sample = (q > 32768) ? -16'sd32768 : 16'(-longint'(q));
      else res.sample = (q > 32767) ? 16'sd32767 : 16'(q);
      tone_ph = (tone_ph + tone_inc) & PMASK;
      wob_ph = (wob_ph + wob_inc) & PMASK;
      frame_at = (frame_at + 1) & 64'hFF_FFFF;
      if (fin) sounding = 1'b0;
    end
    res.active = act;
    res.last = fin;
    return res;
  endfunction

  // receiver backpressure
  always @(posedge clk) begin
    out_stall <= steady ? 1'b0 : ($urandom_range(99) < 28);
  end

  // result checker
  always @(posedge clk) begin
    out_item_t want;
    if (!rst && out_valid && !out_stall) begin
      if (tick_results_q.size() == 0) begin
        $error("unexpected sample transfer: sample %0d", out_data.sample);
        fail_count++;
      end else begin
        want = tick_results_q.pop_front();
        samples_checked++;
        if (out_data.last) notes_ended++;
        if (out_data.sample !== want.sample) begin
          $error("sample: expected %0d, got %0d", want.sample, out_data.sample);
          fail_count++;
        end
        if (out_data.active !== want.active) begin
          $error("active: expected %0b, got %0b", want.active, out_data.active);
          fail_count++;
        end
        if (out_data.last !== want.last) begin
          $error("last: expected %0b, got %0b", want.last, out_data.last);
          fail_count++;
        end
      end
    end
  end

  // watchdog on cycles with no transfer at all
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("watchdog expired with %0d samples pending", tick_results_q.size());
      $display("** note_tone_generator_unit: FAILED **");
      $finish;
    end
  end

  task automatic send_tick(in_item_t it);
    if (!steady && $urandom_range(99) < 28) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= it;
    do @(posedge clk); while (in_stall);
    if (it.start_req) notes_started++;
    tick_results_q.insert(tick_results_q.size(), synth_tick(it));
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (tick_results_q.size() != 0) @(posedge clk);
    repeat (150) @(posedge clk);
  endtask

  task automatic write_rate(logic [SR_W-1:0] sr);
    drain();
    cfg_valid <= 1'b1;
    cfg_data <= sr;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    rate_hz = sr;
  endtask

  function automatic in_item_t make_note(logic [6:0] nt, logic [6:0] vel, logic [23:0] len,
                                         logic [15:0] dep, logic [15:0] rt);
    in_item_t it;
    it.start_req = 1'b1;
    it.midi_note = nt;
    it.velocity = vel;
    it.frame_count = len;
    it.vibrato_depth = dep;
    it.vibrato_rate = rt;
    return it;
  endfunction

  function automatic in_item_t noise_tick();
    in_item_t it;
    it = in_item_t'(71'({$urandom, $urandom, $urandom}));
    it.start_req = 1'b0;
    return it;
  endfunction

  task automatic play(in_item_t note, int unsigned ticks);
    send_tick(note);
    repeat (ticks) send_tick(noise_tick());
  endtask

  task automatic test_directed();
    play(noise_tick(), 1);                              // idle tick before any note
    play(make_note(7'd69, 7'd127, 24'd20, 16'd0, 16'd0), 20);
    play(make_note(7'd0, 7'd127, 24'd1, 16'd65535, 16'd65535), 1);
    play(make_note(7'd127, 7'd0, 24'd2, 16'd65, 16'd1000), 1);
    play(make_note(7'd127, 7'd127, 24'd0, 16'd66, 16'd1280), 1);   // zero length
    play(make_note(7'd60, 7'd100, 24'hFF_FFFF, 16'd66, 16'd0), 3);
    play(make_note(7'd81, 7'd127, 24'd40, 16'd65535, 16'hFFFF), 4); // restart mid-note
    play(make_note(7'd57, 7'd1, 24'd3, 16'd32768, 16'd1), 3);
  endtask

  function automatic in_item_t random_note();
    int unsigned pick;
    logic [23:0] len;
    logic [15:0] dep;
    pick = $urandom_range(99);
    if (pick < 80) len = 24'($urandom_range(1, 80));
    else if (pick < 95) len = 24'($urandom_range(81, 400));
    else if (pick < 98) len = 24'($urandom);
    else len = 0;
    pick = $urandom_range(9);
    dep = (pick == 0) ? 16'd0 : (pick == 1) ? 16'd65 : (pick == 2) ? 16'd66 :
          (pick == 3) ? 16'hFFFF : 16'($urandom);
    return make_note(7'($urandom), 7'($urandom), len, dep,
                     ($urandom_range(9) == 0) ? 16'd0 : 16'($urandom));
  endfunction

  task automatic test_random_notes(int unsigned items, bit hold_off);
    in_item_t nt;
    int unsigned sent, run;
    sent = 0;
    while (sent < items) begin
      nt = random_note();
      if ($urandom_range(9) == 0) run = $urandom_range(0, 8);   // cut short or noise
      else run = (nt.frame_count > 420) ? $urandom_range(5, 30) : nt.frame_count
                                          + $urandom_range(0, 2);
      if (run > 120) run = 120;
      play(nt, run);
      sent += run + 1;
      if (hold_off && sent > items / 2) begin
        drain();
        hold_off = 1'b0;
      end
    end
  endtask

  task automatic test_rate_sweep();
    logic [SR_W-1:0] rates[6] = '{18'd8000, 18'd192000, 18'd0, 18'h3FFFF, 18'd48000, 18'd0};
    rates[5] = SR_W'($urandom);
    foreach (rates[k]) begin
      write_rate(rates[k]);
      steady = (k == 1);
      test_random_notes(230, k == 4);
    end
    steady = 1'b0;
  endtask

  initial begin
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    test_directed();
    test_random_notes(90, 1'b0);
    test_rate_sweep();
    drain();
    $display("covered %0d notes started, %0d note ends, %0d samples checked",
             notes_started, notes_ended, samples_checked);
    $display("sample rates swept from 0 through 262143, vibrato bypass and restarts included");
    if (fail_count == 0)
      $display("** note_tone_generator_unit: PASSED **");
    else
      $display("** note_tone_generator_unit: FAILED **");
    $finish;
  end

endmodule
